>>> rtl/core/tmwm_pkg.sv
// shared constants and types for the tilt median wheel mixer
package tmwm_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int CNT_W       = $clog2(WINDOW_SIZE);
    localparam int RANK_W      = $clog2(WINDOW_SIZE);
    localparam int MID_RANK    = WINDOW_SIZE / 2;
    localparam int LAST_SAMPLE = WINDOW_SIZE - 1;

    localparam int ANGLE_W = 8;
    localparam int MAP_W   = 8;
    localparam int SPEED_W = 10;
    localparam int DZ_W    = 9;

    localparam int ANGLE_MAX       = 90;
    localparam int MIX_MAX         = 127;
    localparam int SPEED_MAX       = 399;
    localparam int DEAD_ZONE_RESET = 20;

    // (a+90)*127/90 as a multiply by 127*ceil(2^22/90) and a shift by 22
    localparam int MAP_SHIFT = 22;
    localparam int MAP_RECIP = 127 * 46604;

    // 18*m/127 as a multiply by 18*ceil(2^20/127) and a shift by 20
    localparam int FRAC_SHIFT = 20;
    localparam int FRAC_RECIP = 18 * 8257;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [MAP_W-1:0]   map_t;
    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [WINDOW_SIZE-1:0][ANGLE_W-1:0] win_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } tmwm_stage_ctl_t;

endpackage

>>> rtl/core/tmwm_lane.sv
// one axis lane: median of the group, then linear map to +-127
module tmwm_lane
    import tmwm_pkg::*;
(
    input  logic            clk,
    input  win_t            samples,
    input  tmwm_stage_ctl_t ctl,
    output map_t            mapped
);

    logic [RANK_W-1:0] rank [WINDOW_SIZE];
    angle_t            med;
    angle_t            med_reg;
    logic [30:0]       prod_reg;
    logic [30:0]       prod_next;
    logic [ANGLE_W:0]  offset;
    logic [9:0]        mapped_wide;

    // rank of each element, ties broken by position; the middle rank is the median
    always_comb
    begin
        med = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++)
            begin
                if (j != i)
                begin
                    if (($signed(samples[j]) < $signed(samples[i])) ||
                        ((samples[j] == samples[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
            if (rank[i] == RANK_W'(MID_RANK))
            begin
                med = samples[i];
            end
        end
    end

    assign offset    = 9'({med_reg[ANGLE_W-1], med_reg}) + 9'(ANGLE_MAX);
    assign prod_next = 31'(offset[ANGLE_W-1:0]) * 31'(MAP_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            med_reg <= med;
        end
        if (ctl.ld2)
        begin
            prod_reg <= prod_next;
        end
    end

    assign mapped_wide = {1'b0, prod_reg[30:MAP_SHIFT]} - 10'(MIX_MAX);
    assign mapped      = mapped_wide[MAP_W-1:0];

endmodule

>>> rtl/core/tmwm_mixer.sv
// merge stage: mixes the two axes into wheel speeds, rescales, dead zone and clamp
module tmwm_mixer
    import tmwm_pkg::*;
(
    input  logic            clk,
    input  map_t            pitch_map,
    input  map_t            roll_map,
    input  logic [DZ_W-1:0] dead_zone,
    input  tmwm_stage_ctl_t ctl,
    output speed_t          speed13,
    output speed_t          speed24
);

    typedef struct packed {
        logic        neg;
        logic [8:0]  mag;
        logic [26:0] frac_prod;
    } shape_t;

    function automatic shape_t shape_front(input logic signed [8:0] s);
        logic [9:0] t;
        logic [9:0] t_abs;
        shape_t     r;
        t           = 10'({s[8], s}) + 10'(MIX_MAX);
        r.neg       = t[9];
        t_abs       = t[9] ? (10'd0 - t) : t;
        r.mag       = t_abs[8:0];
        r.frac_prod = 27'(r.mag) * 27'(FRAC_RECIP);
        return r;
    endfunction

    function automatic speed_t shape_back(input shape_t f, input logic [DZ_W-1:0] dz);
        logic [10:0]        q;
        logic signed [11:0] v;
        logic [11:0]        v_abs;
        speed_t             r;
        // truncating division: magnitude quotient, sign applied afterwards
        q     = 11'({f.mag, 1'b0}) + 11'(f.mag) + 11'(f.frac_prod[26:FRAC_SHIFT]);
        v     = f.neg ? (12'sd0 - $signed({1'b0, q})) : $signed({1'b0, q});
        v     = v - 12'sd399;
        v_abs = v[11] ? 12'(-v) : 12'(v);
        priority if (v_abs < 12'(dz))
            r = '0;
        else if (v > 12'(SPEED_MAX))
            r = SPEED_W'(SPEED_MAX);
        else if (v < -12'(SPEED_MAX))
            r = SPEED_W'(-SPEED_MAX);
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

    logic signed [8:0] s13;
    logic signed [8:0] s24;
    shape_t            f13_reg;
    shape_t            f24_reg;
    speed_t            speed13_reg;
    speed_t            speed24_reg;

    assign s13 = 9'(roll_map) - 9'(pitch_map);
    assign s24 = 9'sd0 - 9'(pitch_map) - 9'(roll_map);

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            f13_reg <= shape_front(s13);
            f24_reg <= shape_front(s24);
        end
        if (ctl.ld4)
        begin
            speed13_reg <= shape_back(f13_reg, dead_zone);
            speed24_reg <= shape_back(f24_reg, dead_zone);
        end
    end

    assign speed13 = speed13_reg;
    assign speed24 = speed24_reg;

endmodule

>>> rtl/core/tilt_median_wheel_mixer.sv
// top level: sample window, pipeline control, two axis lanes and the wheel mixer
// throughput: one input word per cycle while in_ready is high; one output word per group of five inputs
// out_valid rises once the fifth word of a group is accepted and has passed the registers of the
// median stage, map multiply stage, mix multiply stage and output register, in that order
// in_ready drops only on the last word of a group while the pipeline is full and out_ready is low
// reset: rst_n asynchronous, clears the sample count and stage valids, dead_zone to 20
module tilt_median_wheel_mixer
    import tmwm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [DZ_W-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  angle_t          pitch_angle,
    input  angle_t          roll_angle,
    output logic            out_valid,
    input  logic            out_ready,
    output speed_t          wheel_one_speed,
    output speed_t          wheel_two_speed,
    output speed_t          wheel_three_speed,
    output speed_t          wheel_four_speed
);

    function automatic angle_t sat_angle(input angle_t a);
        angle_t r;
        priority if (a > ANGLE_W'(ANGLE_MAX))
            r = ANGLE_W'(ANGLE_MAX);
        else if (a < -ANGLE_W'(ANGLE_MAX))
            r = -ANGLE_W'(ANGLE_MAX);
        else
            r = a;
        return r;
    endfunction

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DZ_W-1:0]  dead_zone_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             out_valid_reg;
    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             rdy4;
    logic             last_sample;
    logic             in_accept;
    logic             fire;
    angle_t           pitch_sat;
    angle_t           roll_sat;
    angle_t           pitch_win_reg [WINDOW_SIZE-1];
    angle_t           roll_win_reg [WINDOW_SIZE-1];
    win_t             pitch_samples;
    win_t             roll_samples;
    tmwm_stage_ctl_t  ctl;
    map_t             pitch_map;
    map_t             roll_map;
    speed_t           speed13;
    speed_t           speed24;

    assign pitch_sat = sat_angle(pitch_angle);
    assign roll_sat  = sat_angle(roll_angle);

    // a stage loads when it is empty or its word moves on
    assign rdy4 = !out_valid_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign last_sample = (cnt_reg == CNT_W'(LAST_SAMPLE));
    assign in_ready    = !last_sample || rdy1;
    assign in_accept   = in_valid && in_ready;
    assign fire        = in_accept && last_sample;
    assign cnt_next    = last_sample ? '0 : cnt_reg + CNT_W'(1);
    assign cfg_ready   = 1'b1;

    assign ctl.ld1 = rdy1;
    assign ctl.ld2 = rdy2;
    assign ctl.ld3 = rdy3;
    assign ctl.ld4 = rdy4;

    // newest word at the bottom of the group, the rest from the shift line
    always_comb
    begin
        pitch_samples[0] = pitch_sat;
        roll_samples[0]  = roll_sat;
        for (int k = 1; k < WINDOW_SIZE; k++)
        begin
            pitch_samples[k] = pitch_win_reg[k-1];
            roll_samples[k]  = roll_win_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pitch_win_reg[0] <= pitch_sat;
            roll_win_reg[0]  <= roll_sat;
            for (int k = 1; k < WINDOW_SIZE - 1; k++)
            begin
                pitch_win_reg[k] <= pitch_win_reg[k-1];
                roll_win_reg[k]  <= roll_win_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            dead_zone_reg <= DZ_W'(DEAD_ZONE_RESET);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                cnt_reg <= cnt_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                dead_zone_reg <= cfg_data;
            end
            if (rdy1)
            begin
                v1_reg <= fire;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    tmwm_lane u_pitch_lane (
        .clk     (clk),
        .samples (pitch_samples),
        .ctl     (ctl),
        .mapped  (pitch_map)
    );

    tmwm_lane u_roll_lane (
        .clk     (clk),
        .samples (roll_samples),
        .ctl     (ctl),
        .mapped  (roll_map)
    );

    tmwm_mixer u_mixer (
        .clk       (clk),
        .pitch_map (pitch_map),
        .roll_map  (roll_map),
        .dead_zone (dead_zone_reg),
        .ctl       (ctl),
        .speed13   (speed13),
        .speed24   (speed24)
    );

    assign out_valid         = out_valid_reg;
    assign wheel_one_speed   = speed13;
    assign wheel_two_speed   = speed24;
    assign wheel_three_speed = speed13;
    assign wheel_four_speed  = speed24;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LAST_SAMPLE))
        else $error("sample count past end of group");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !last_sample) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("sample count did not advance");

    a_stall_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (last_sample && v1_reg && v2_reg && v3_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((speed13 <= SPEED_W'(SPEED_MAX)) && (speed13 >= -SPEED_W'(SPEED_MAX)) &&
                       (speed24 <= SPEED_W'(SPEED_MAX)) && (speed24 >= -SPEED_W'(SPEED_MAX))))
        else $error("wheel speed out of range");

endmodule
